// File: hw/rtl/nps_pkg.sv
// nps_pkg: shared types and codes of the nearest point snap search block
// depends on nothing; used by nps_dist_unit and nearest_point_snap_search
package nps_pkg;

    // item opcodes
    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_APPEND = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;

    // result status codes
    localparam logic [2:0] ST_DONE     = 3'd0;
    localparam logic [2:0] ST_FULL     = 3'd1;
    localparam logic [2:0] ST_DISABLED = 3'd2;
    localparam logic [2:0] ST_NONE     = 3'd3;
    localparam logic [2:0] ST_KEPT     = 3'd4;
    localparam logic [2:0] ST_NEW      = 3'd5;

    // configuration register indexes (paddr[2])
    localparam logic REG_ENABLE = 1'b0;
    localparam logic REG_RADIUS = 1'b1;

    // squared distance inside the window: two squares of at most 255
    localparam int DIST_W = 17;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [1:0]         point_group;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic [15:0]        point_tag;
    } t_in_item;

    typedef struct packed {
        logic [2:0]         status;
        logic               has_snap;
        logic signed [15:0] snap_x;
        logic signed [15:0] snap_y;
        logic [15:0]        snap_tag;
    } t_out_item;

    // one stored candidate point
    typedef struct packed {
        logic [1:0]         group;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [15:0]        tag;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // one evaluated candidate leaving the distance unit
    typedef struct packed {
        logic                valid;
        logic                in_win;
        logic [DIST_W-1:0]   sq_dist;
        t_entry              entry;
    } t_dist_res;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_FINISH
    } t_state;

endpackage

// File: hw/rtl/nps_ram.sv
// nps_ram: generic single write port, single read port ram with registered read
// depends on nothing
module nps_ram #(
    parameter int WIDTH = 50,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/nps_dist_unit.sv
// nps_dist_unit: two stage window test and squared distance of one candidate a cycle
// depends on nps_pkg
module nps_dist_unit (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  nps_pkg::t_entry       i_entry,
    input  logic signed [15:0]    i_cx,
    input  logic signed [15:0]    i_cy,
    input  logic [7:0]            i_radius,
    output nps_pkg::t_dist_res    o_res,
    output logic                  o_busy
);

    logic signed [16:0] w_dx;
    logic signed [16:0] w_dy;
    logic signed [16:0] w_r;
    logic signed [16:0] w_neg_r;
    logic               w_in_win;
    logic signed [17:0] w_sqx;
    logic signed [17:0] w_sqy;

    logic               r_a_valid;
    logic               r_a_in;
    logic signed [8:0]  r_a_dx;
    logic signed [8:0]  r_a_dy;
    nps_pkg::t_entry    r_a_entry;

    logic               r_b_valid;
    logic               r_b_in;
    logic [15:0]        r_b_sqx;
    logic [15:0]        r_b_sqy;
    nps_pkg::t_entry    r_b_entry;

    // window is -r < d <= r on both axes, so an inside offset fits 9 bits
    assign w_dx     = {i_cx[15], i_cx} - {i_entry.x[15], i_entry.x};
    assign w_dy     = {i_cy[15], i_cy} - {i_entry.y[15], i_entry.y};
    assign w_r      = {9'd0, i_radius};
    assign w_neg_r  = -w_r;
    assign w_in_win = (w_dx <= w_r) && (w_dx > w_neg_r) && (w_dy <= w_r) && (w_dy > w_neg_r);

    assign w_sqx = r_a_dx * r_a_dx;
    assign w_sqy = r_a_dy * r_a_dy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            r_a_valid <= i_valid;
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_in    <= w_in_win;
        r_a_dx    <= w_dx[8:0];
        r_a_dy    <= w_dy[8:0];
        r_a_entry <= i_entry;
        r_b_in    <= r_a_in;
        r_b_sqx   <= w_sqx[15:0];
        r_b_sqy   <= w_sqy[15:0];
        r_b_entry <= r_a_entry;
    end

    always_comb begin
        o_res.valid   = r_b_valid;
        o_res.in_win  = r_b_in;
        o_res.sq_dist = {1'b0, r_b_sqx} + {1'b0, r_b_sqy};
        o_res.entry   = r_b_entry;
    end

    assign o_busy = r_a_valid || r_b_valid;

endmodule

// File: hw/rtl/nearest_point_snap_search.sv
// nearest_point_snap_search: top level, sequencer, candidate table and held snap point
// depends on nps_pkg, nps_ram and nps_dist_unit
//
// Keeps a table of up to TABLE_DEPTH snap points and answers every input item with
// exactly one result item. Clear, append and ignored queries finish in the cycle
// after acceptance. A query walks the table through one shared distance unit, one
// stored point per cycle out of the table ram. Its result is loaded once the ram
// read port and the distance unit pipeline have drained and the output register is
// free. The block takes no new item while a query runs, and it takes an item only
// when the output register is free or being emptied. The table has no clearing pass:
// clear resets the fill count and drops the held point, and entries above the fill
// count are never read.
// Registers: snap_enable at byte 0, snap_radius at byte 4.
module nearest_point_snap_search #(
    parameter int TABLE_DEPTH = 256
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // input item channel
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  nps_pkg::t_in_item    i_in_item,
    // result item channel
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output nps_pkg::t_out_item   o_out_item,
    // configuration port
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    // control state
    nps_pkg::t_state      r_state, n_state;
    logic [CW-1:0]        r_count, n_count;
    logic [CW-1:0]        r_idx, n_idx;
    logic                 r_rd_valid, n_rd_valid;
    logic                 r_found, n_found;
    logic                 r_hold, n_hold;
    logic signed [15:0]   r_hx, n_hx;
    logic signed [15:0]   r_hy, n_hy;
    logic [15:0]          r_htag, n_htag;
    logic                 r_en, n_en;
    logic [7:0]           r_radius, n_radius;
    logic                 r_out_valid, n_out_valid;

    // payload
    logic signed [15:0]   r_cx, n_cx;
    logic signed [15:0]   r_cy, n_cy;
    logic [nps_pkg::DIST_W-1:0] r_best_d, n_best_d;
    nps_pkg::t_entry      r_best, n_best;
    nps_pkg::t_out_item   r_out, n_out;

    // datapath glue
    logic                 w_out_free;
    logic                 w_accept;
    logic                 w_cfg_wr;
    logic                 w_load;
    logic [2:0]           w_status;
    logic                 w_we;
    logic                 w_re;
    logic                 w_better;
    nps_pkg::t_entry      w_wentry;
    nps_pkg::t_entry      w_rentry;
    nps_pkg::t_dist_res   w_res;
    logic                 w_busy;

    function automatic nps_pkg::t_out_item mk_out(
        input logic [2:0]         status,
        input logic               hold,
        input logic signed [15:0] x,
        input logic signed [15:0] y,
        input logic [15:0]        tag
    );
        nps_pkg::t_out_item o;
        o.status   = status;
        o.has_snap = hold;
        o.snap_x   = hold ? x : 16'sd0;
        o.snap_y   = hold ? y : 16'sd0;
        o.snap_tag = hold ? tag : 16'd0;
        return o;
    endfunction

    assign w_out_free = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == nps_pkg::S_IDLE) && w_out_free;
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_cfg_wr   = psel && penable && pwrite;

    assign pready = 1'b1;

    always_comb begin
        case (paddr[2])
            nps_pkg::REG_ENABLE: prdata = {31'd0, r_en};
            nps_pkg::REG_RADIUS: prdata = {24'd0, r_radius};
            default:             prdata = 32'd0;
        endcase
    end

    // candidate table, one word per stored point
    assign w_wentry.group = i_in_item.point_group;
    assign w_wentry.x     = i_in_item.pos_x;
    assign w_wentry.y     = i_in_item.pos_y;
    assign w_wentry.tag   = i_in_item.point_tag;

    nps_ram #(
        .WIDTH (nps_pkg::ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (w_wentry),
        .i_re    (w_re),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (w_rentry)
    );

    // shared window and distance unit, fed straight from the ram read port
    nps_dist_unit u_dist (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (r_rd_valid),
        .i_entry  (w_rentry),
        .i_cx     (r_cx),
        .i_cy     (r_cy),
        .i_radius (r_radius),
        .o_res    (w_res),
        .o_busy   (w_busy)
    );

    // strict less distance wins, an equal one only with a lower group, so the
    // earlier append keeps the tie otherwise
    assign w_better = w_res.valid && w_res.in_win &&
                      (!r_found || (w_res.sq_dist < r_best_d) ||
                       ((w_res.sq_dist == r_best_d) && (w_res.entry.group < r_best.group)));

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_idx       = r_idx;
        n_rd_valid  = 1'b0;
        n_found     = r_found;
        n_hold      = r_hold;
        n_hx        = r_hx;
        n_hy        = r_hy;
        n_htag      = r_htag;
        n_en        = r_en;
        n_radius    = r_radius;
        n_out_valid = r_out_valid && !i_out_ready;
        n_cx        = r_cx;
        n_cy        = r_cy;
        n_best_d    = r_best_d;
        n_best      = r_best;
        n_out       = r_out;
        w_load      = 1'b0;
        w_status    = nps_pkg::ST_DONE;
        w_we        = 1'b0;
        w_re        = 1'b0;

        // config writes must come only while idle; the block itself does not enforce it
        if (w_cfg_wr) begin
            case (paddr[2])
                nps_pkg::REG_ENABLE: n_en     = pwdata[0];
                nps_pkg::REG_RADIUS: n_radius = pwdata[7:0];
                default:             n_en     = r_en;
            endcase
        end

        if (w_better) begin
            n_found  = 1'b1;
            n_best_d = w_res.sq_dist;
            n_best   = w_res.entry;
        end

        case (r_state)
            nps_pkg::S_IDLE: begin
                if (w_accept) begin
                    case (i_in_item.opcode)
                        nps_pkg::OP_CLEAR: begin
                            n_count = '0;
                            n_hold  = 1'b0;
                            w_load  = 1'b1;
                        end
                        nps_pkg::OP_APPEND: begin
                            w_load = 1'b1;
                            if (r_count == CW'(TABLE_DEPTH)) begin
                                w_status = nps_pkg::ST_FULL;
                            end else begin
                                w_we    = 1'b1;
                                n_count = r_count + 1'b1;
                            end
                        end
                        nps_pkg::OP_QUERY: begin
                            if (!r_en) begin
                                w_status = nps_pkg::ST_DISABLED;
                                w_load   = 1'b1;
                            end else begin
                                n_cx    = i_in_item.pos_x;
                                n_cy    = i_in_item.pos_y;
                                n_idx   = '0;
                                n_found = 1'b0;
                                n_state = nps_pkg::S_SCAN;
                            end
                        end
                        default: begin
                            w_load = 1'b1;
                        end
                    endcase
                end
            end
            nps_pkg::S_SCAN: begin
                // one table read a cycle until the fill count is reached
                if (r_idx != r_count) begin
                    w_re       = 1'b1;
                    n_rd_valid = 1'b1;
                    n_idx      = r_idx + 1'b1;
                end else begin
                    n_state = nps_pkg::S_DRAIN;
                end
            end
            nps_pkg::S_DRAIN: begin
                if (!r_rd_valid && !w_busy) begin
                    n_state = nps_pkg::S_FINISH;
                end
            end
            nps_pkg::S_FINISH: begin
                if (w_out_free) begin
                    w_load  = 1'b1;
                    n_state = nps_pkg::S_IDLE;
                    if (!r_found) begin
                        w_status = nps_pkg::ST_NONE;
                        n_hold   = 1'b0;
                    end else if (r_hold && (r_best.x == r_hx) && (r_best.y == r_hy)) begin
                        // same pixel position keeps the held point and its tag
                        w_status = nps_pkg::ST_KEPT;
                    end else begin
                        w_status = nps_pkg::ST_NEW;
                        n_hold   = 1'b1;
                        n_hx     = r_best.x;
                        n_hy     = r_best.y;
                        n_htag   = r_best.tag;
                    end
                end
            end
            default: begin
                n_state = nps_pkg::S_IDLE;
            end
        endcase

        if (w_load) begin
            n_out_valid = 1'b1;
            n_out       = mk_out(w_status, n_hold, n_hx, n_hy, n_htag);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= nps_pkg::S_IDLE;
            r_count     <= '0;
            r_idx       <= '0;
            r_rd_valid  <= 1'b0;
            r_found     <= 1'b0;
            r_hold      <= 1'b0;
            r_hx        <= '0;
            r_hy        <= '0;
            r_htag      <= '0;
            r_en        <= 1'b0;
            r_radius    <= 8'd5;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_idx       <= n_idx;
            r_rd_valid  <= n_rd_valid;
            r_found     <= n_found;
            r_hold      <= n_hold;
            r_hx        <= n_hx;
            r_hy        <= n_hy;
            r_htag      <= n_htag;
            r_en        <= n_en;
            r_radius    <= n_radius;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cx     <= n_cx;
        r_cy     <= n_cy;
        r_best_d <= n_best_d;
        r_best   <= n_best;
        r_out    <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // table port never reads and writes in one cycle
    a_no_rw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_we && w_re))
        else $error("table read and write in the same cycle");

    // fill count never passes the table depth
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(TABLE_DEPTH))
        else $error("fill count beyond table depth");

    // reads stay below the fill count
    a_rd_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_re |-> (r_idx < r_count))
        else $error("table read above fill count");

    // a distance result only arrives while a query is in flight
    a_res_in_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res.valid |-> (r_state == nps_pkg::S_SCAN || r_state == nps_pkg::S_DRAIN))
        else $error("distance result outside a query");

    // a kept or new result always carries a held point
    a_kept_has_snap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_item.status == nps_pkg::ST_KEPT ||
                         o_out_item.status == nps_pkg::ST_NEW)) |-> o_out_item.has_snap)
        else $error("snap result without a held point");

endmodule
